// ===== rtl/aes_pkg.sv =====
// Package with the AES-128 types, S-box and round helper functions.
package aes_pkg;

  localparam int unsigned Rounds = 10;

  typedef logic [127:0] block_t;
  typedef logic [7:0]   byte_t;

  // Data travelling between round cells.
  typedef struct packed {
    logic   valid;
    block_t state;
    block_t rkey;
    byte_t  rcon;
  } beat_t;

  function automatic byte_t sbox(input byte_t a);
    byte_t r;
    case (a)
      8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
      8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
      8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
      8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
      8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
      8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
      8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
      8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
      8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
      8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
      8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
      8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
      8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
      8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
      8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
      8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
      8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
      8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
      8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
      8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
      8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
      8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
      8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
      8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
      8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
      8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
      8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
      8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
      8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
      8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
      8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
      8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
      8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
      8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
      8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
      8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
      8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
      8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
      8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
      8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
      8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
      8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
      8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
      8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
      8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
      8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
      8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
      8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
      8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
      8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
      8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
      8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
      8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
      8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
      8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
      8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
      8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
      8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
      8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
      8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
      8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
      8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
      8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
      8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; default: r=8'h16;
    endcase
    return r;
  endfunction

  function automatic byte_t xtime(input byte_t b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  // Next round key from the current one.
  function automatic block_t next_key(input block_t k, input byte_t rc);
    logic [31:0] t;
    logic [31:0] w0, w1, w2, w3;
    t = {sbox(k[23:16]), sbox(k[15:8]), sbox(k[7:0]), sbox(k[31:24])} ^ {rc, 24'h0};
    w0 = k[127:96] ^ t;
    w1 = k[95:64] ^ w0;
    w2 = k[63:32] ^ w1;
    w3 = k[31:0] ^ w2;
    return {w0, w1, w2, w3};
  endfunction

  // SubBytes, ShiftRows and, unless last, MixColumns. Byte n at bits 127-8n.
  function automatic block_t round_fn(input block_t s, input logic last);
    byte_t t [16];
    byte_t a0, a1, a2, a3, al;
    block_t o;
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        t[4*c+i] = sbox(s[127 - 8*(4*((c+i)%4)+i) -: 8]);
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
      al = a0 ^ a1 ^ a2 ^ a3;
      if (!last) begin
        o[127-32*c -: 8]  = a0 ^ al ^ xtime(a0 ^ a1);
        o[119-32*c -: 8]  = a1 ^ al ^ xtime(a1 ^ a2);
        o[111-32*c -: 8]  = a2 ^ al ^ xtime(a2 ^ a3);
        o[103-32*c -: 8]  = a3 ^ al ^ xtime(a3 ^ a0);
      end else begin
        o[127-32*c -: 8]  = a0;
        o[119-32*c -: 8]  = a1;
        o[111-32*c -: 8]  = a2;
        o[103-32*c -: 8]  = a3;
      end
    end
    return o;
  endfunction

endpackage

// ===== rtl/aes_round_cell.sv =====
// One round cell: applies a round to its state and derives the next round key.
module aes_round_cell #(
  parameter bit Last = 1'b0
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           advance,
  input  aes_pkg::beat_t din,
  output aes_pkg::beat_t dout
);

  aes_pkg::block_t key_next;

  assign key_next = aes_pkg::next_key(din.rkey, din.rcon);

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (advance) begin
      dout.valid <= din.valid;
    end
    if (advance) begin
      dout.state <= aes_pkg::round_fn(din.state, Last) ^ key_next;
      dout.rkey  <= key_next;
      dout.rcon  <= aes_pkg::xtime(din.rcon);
    end
  end

endmodule

// ===== rtl/aes128_block_encrypt.sv =====
// Top level of the AES-128 encryptor: key registers, input stage and round cells.
// Usage:
// Write key_high at byte address 0 and key_low at 8 over the APB port while
// no block is in flight; a read returns the register. Each cell derives its
// round key on the fly from the key carried along with the block.
// Plaintext beats are taken when in_valid is high and in_stall low; results
// appear on out_valid with cipher_high/cipher_low and leave when out_stall
// is low.
// The input stage does the first AddRoundKey as it registers an accepted
// beat, and each of the ten round cells adds a register before out_valid.
// Throughput: one block per cycle while out_stall is low, as every round has
// a cell of its own. When out_stall holds the last cell full, the unbroken
// run of full stages behind it freezes, and in_stall rises only while the
// chain cannot move. Holes in the chain are filled even while the output is stalled.
// Reset clears all valid flags and both key registers.
module aes128_block_encrypt (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] plain_high,
  input  logic [63:0] plain_low,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] cipher_high,
  output logic [63:0] cipher_low
);

  localparam logic [3:0] AddrKeyHigh = 4'h0;
  localparam logic [3:0] AddrKeyLow  = 4'h8;
  localparam int unsigned N = aes_pkg::Rounds;

  logic [63:0] key_high;
  logic [63:0] key_low;
  aes_pkg::beat_t stage [N+1];
  logic [N:0] advance;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low  <= '0;
    end else if (psel && penable && pwrite) begin
      case (paddr)
        AddrKeyHigh: key_high <= pwdata;
        AddrKeyLow:  key_low  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      AddrKeyHigh: prdata = key_high;
      AddrKeyLow:  prdata = key_low;
      default:     prdata = '0;
    endcase
  end

  // A stage may take new data when it is empty or the one after it moves.
  always_comb begin
    advance[N] = !stage[N].valid || !out_stall;
    for (int i = N - 1; i >= 0; i--) begin
      advance[i] = !stage[i].valid || advance[i+1];
    end
  end

  assign in_stall = !advance[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      stage[0].valid <= 1'b0;
    end else if (advance[0]) begin
      stage[0].valid <= in_valid;
    end
    if (advance[0]) begin
      stage[0].state <= {plain_high, plain_low} ^ {key_high, key_low};
      stage[0].rkey  <= {key_high, key_low};
      stage[0].rcon  <= 8'h01;
    end
  end

  for (genvar g = 1; g <= N; g++) begin : g_cell
    aes_round_cell #(.Last(g == N)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .advance (advance[g]),
      .din     (stage[g-1]),
      .dout    (stage[g])
    );
  end

  assign out_valid   = stage[N].valid;
  assign cipher_high = stage[N].state[127:64];
  assign cipher_low  = stage[N].state[63:0];

endmodule

// ===== rtl/aes128_block_encrypt_checker.sv =====
// Port-level checker for the AES-128 encryptor, bound to the top level.
module aes128_block_encrypt_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [63:0] cipher_high,
  input logic [63:0] cipher_low
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(cipher_high) && $stable(cipher_low))
    else $error("stalled result changed");

  a_no_stall_idle: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result after reset");

  a_stall_needs_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output back-pressure");

endmodule

bind aes128_block_encrypt aes128_block_encrypt_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .cipher_high (cipher_high),
  .cipher_low  (cipher_low)
);
